>>> hw/rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the minimum-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

    // default stack depth
    localparam int MTS_DEPTH_DEFAULT = 64;

    // largest positive 32-bit value, reported as minimum of an empty stack
    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

    // operation codes
    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_PEEK  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    // status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_RD_TOP = 2'd1,
        S_RD_MIN = 2'd2,
        S_FIN    = 2'd3
    } t_mts_state;

    // input transaction
    typedef struct packed {
        t_action            action;
        logic signed [31:0] push_value;
    } t_mts_in;

    // result transaction
    typedef struct packed {
        logic signed [31:0] data_out;
        logic signed [31:0] current_min;
        logic [6:0]         entry_count;
        logic signed [31:0] bottom_value;
        t_status            status;
    } t_mts_out;

    // one stack word: value and minimum of all entries up to and including it
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] pmin;
    } t_mts_entry;

endpackage

>>> hw/rtl/min_tracking_stack.sv
// Acceptance to result register: push, clear and refused operations go to
// S_FIN; peek reads the top in S_RD_TOP; pop also reads the new top's prefix
// minimum in S_RD_MIN (two reads of the single-port, registered-read stack
// RAM) unless it empties the stack. One transaction is in work at a time.
// Reset (synchronous, active low) empties the stack and sets the minimum to
// INT_MAX; the stack RAM itself is not cleared.
// ----------------------------------------------------------------------------
// min_tracking_stack
// Bounded stack of signed 32-bit values reporting the minimum of its
// contents. Each entry stores its prefix minimum, so a pop restores the
// minimum from the entry below without a rescan.
// ----------------------------------------------------------------------------
module min_tracking_stack #(
    parameter int STACK_DEPTH = mts_pkg::MTS_DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  mts_pkg::t_mts_in i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output mts_pkg::t_mts_out o_out_data
);
    import mts_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_mts_state         r_state, n_state;
    t_action            r_act, n_act;
    logic signed [31:0] r_data, n_data;
    t_status            r_status, n_status;
    logic [CW-1:0]      r_count, n_count;
    logic signed [31:0] r_min, n_min;
    logic signed [31:0] r_bottom, n_bottom;
    logic               r_out_valid, n_out_valid;
    t_mts_out           r_out, n_out;

    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_addr;
    t_mts_entry         mem_wdata;
    t_mts_entry         mem_rdata;
    logic signed [31:0] push_min;
    logic               empty;
    logic               full;

    assign empty = (r_count == '0);
    assign full  = (r_count == CW'(STACK_DEPTH));

    // compare unit: new prefix minimum for a push
    mts_min_unit u_min (
        .i_first (empty),
        .i_a     (i_in_data.push_value),
        .i_b     (r_min),
        .o_min   (push_min)
    );

    assign mem_wdata.value = i_in_data.push_value;
    assign mem_wdata.pmin  = push_min;

    mts_stack_ram #(
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // sequencer: next state, stack control and result register load
    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_data      = r_data;
        n_status    = r_status;
        n_count     = r_count;
        n_min       = r_min;
        n_bottom    = r_bottom;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = AW'(r_count);

        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act    = i_in_data.action;
                    n_data   = '0;
                    n_status = ST_OK;
                    n_state  = S_FIN;
                    case (i_in_data.action)
                        ACT_PUSH: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = CW'(r_count + 1'b1);
                                n_min   = push_min;
                                if (empty) begin
                                    n_bottom = i_in_data.push_value;
                                end
                            end
                        end
                        ACT_POP, ACT_PEEK: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                mem_re   = 1'b1;
                                mem_addr = AW'(r_count - 1'b1);
                                n_state  = S_RD_TOP;
                                if (i_in_data.action == ACT_POP) begin
                                    n_count = CW'(r_count - 1'b1);
                                end
                            end
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                            n_min   = INT_MAX;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_TOP: begin
                n_data  = mem_rdata.value;
                n_state = S_FIN;
                // pop: fetch prefix minimum of the new top entry
                if (r_act == ACT_POP) begin
                    if (empty) begin
                        n_min = INT_MAX;
                    end else begin
                        mem_re   = 1'b1;
                        mem_addr = AW'(r_count - 1'b1);
                        n_state  = S_RD_MIN;
                    end
                end
            end
            S_RD_MIN: begin
                n_min   = mem_rdata.pmin;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid        = 1'b1;
                    n_out.data_out     = r_data;
                    n_out.current_min  = r_min;
                    n_out.entry_count  = 7'(r_count);
                    n_out.bottom_value = empty ? 32'sd0 : r_bottom;
                    n_out.status       = r_status;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_min       <= INT_MAX;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_min       <= n_min;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_data   <= n_data;
        r_status <= n_status;
        r_bottom <= n_bottom;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> hw/rtl/mts_stack_ram.sv
// ----------------------------------------------------------------------------
// mts_stack_ram
// Single-port stack memory, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module mts_stack_ram #(
    parameter int DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic                        i_re,
    input  logic [$clog2(DEPTH)-1:0]    i_addr,
    input  mts_pkg::t_mts_entry         i_wdata,
    output mts_pkg::t_mts_entry         o_rdata
);
    import mts_pkg::*;

    t_mts_entry r_mem [DEPTH];
    t_mts_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/mts_min_unit.sv
// ----------------------------------------------------------------------------
// mts_min_unit
// Signed 32-bit minimum; passes the new value through for a first entry.
// ----------------------------------------------------------------------------
module mts_min_unit (
    input  logic               i_first,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [31:0] o_min
);
    import mts_pkg::*;

    // signed compare and select
    always_comb begin
        if (i_first || (i_a < i_b)) begin
            o_min = i_a;
        end else begin
            o_min = i_b;
        end
    end

endmodule

>>> hw/rtl/mts_checker.sv
// ----------------------------------------------------------------------------
// mts_port_checks
// Port-level checks for the minimum-tracking stack, bound to the top level.
// ----------------------------------------------------------------------------
module mts_port_checks #(
    parameter int DEPTH = mts_pkg::MTS_DEPTH_DEFAULT
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input mts_pkg::t_mts_in  i_in_data,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input mts_pkg::t_mts_out o_out_data
);
    import mts_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // one transaction in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // refused operations return no data
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |-> (o_out_data.data_out == '0))
        else $error("refused operation returned data");

    // empty stack reports INT_MAX and zero bottom
    a_empty_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (DEPTH < 128 && o_out_valid && o_out_data.entry_count == '0) |->
        (o_out_data.current_min == INT_MAX && o_out_data.bottom_value == '0))
        else $error("empty stack reports stale min or bottom");

    // minimum never exceeds the bottom entry
    a_min_le_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (DEPTH < 128 && o_out_valid && o_out_data.entry_count != '0) |->
        ($signed(o_out_data.current_min) <= $signed(o_out_data.bottom_value)))
        else $error("minimum above bottom entry");

endmodule

bind min_tracking_stack mts_port_checks #(
    .DEPTH (STACK_DEPTH)
) u_mts_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
